/* hw/rtl/lwno_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lwno_pkg
// Shared types and constants of the lidar window nearest-obstacle block.
// ----------------------------------------------------------------------------
package lwno_pkg;

	// field and register widths
	localparam int DEG_W      = 9;   // whole-degree values, signed
	localparam int ANGLE_W    = 19;  // beam angle in millidegrees, signed
	localparam int STEP_W     = 19;  // scan step, unsigned
	localparam int RANGE_W    = 17;  // floor and ceiling registers
	localparam int CFG_DATA_W = 20;  // widest register (scan start)
	localparam int CFG_IDX_W  = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIN_START  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_END    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_STEP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING    = 3'd5;

	// register reset values
	localparam int WIN_START_RST  = -100;
	localparam int WIN_END_RST    = 80;
	localparam int SCAN_STEP_RST  = 1000;
	localparam int FLOOR_RST      = 120;
	localparam int CEILING_RST    = 131071;

	// angle arithmetic
	localparam int FULL_TURN_MDEG = 360000;
	localparam int HALF_TURN_MDEG = 180000;
	localparam int FULL_TURN_DEG  = 360;
	localparam int MDEG_PER_DEG   = 1000;
	localparam int HALF_DEG_MDEG  = 500;

	// divide by 1000 as multiply by 2^28/1000 rounded up, exact below 2^18
	localparam int RECIP_SHIFT    = 28;
	localparam int RECIP_1000     = 268436;
	localparam int RECIP_W        = 19;
	localparam int MAG_W          = 18;
	localparam int ROUND_W        = 8;

	// distance sanitizing
	localparam int                 BAD_READING_MM = 99900;
	localparam logic [RANGE_W-1:0] CEIL_NO_LIMIT  = '1;

	// per-beam evaluation results
	typedef struct packed {
		logic                      in_window;   // beam angle inside the window
		logic                      left_side;   // angle zero or above
		logic signed [DEG_W-1:0]   round_deg;   // angle rounded to whole degrees
		logic signed [ANGLE_W-1:0] next_angle;  // angle of the following beam
	} beam_eval_t;

endpackage

`default_nettype wire

/* hw/rtl/lidar_window_nearest_obstacle_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_window_nearest_obstacle_core
// Nearest obstacle and left/right clearance over an angular lidar window.
// ----------------------------------------------------------------------------
// One beam range is taken per clock cycle. A beam goes into an input register,
// is evaluated and folded into the scan accumulators in the next cycle, and
// the beam marked tlast loads the scan result into the output register, where
// it is offered until taken. Throughput is one beam per cycle, set by the
// single pass from the input register through the beam evaluator to the
// accumulators; the only stall is a last beam that finds the previous result
// still waiting in the output register. Writing the scan start register
// restarts the beam angle at the new start.
module lidar_window_nearest_obstacle_core #(
	parameter int DIST_BITS = 17,
	localparam int IN_TDATA_W  = ((DIST_BITS + 7) / 8) * 8,
	localparam int OUT_TDATA_W = ((lwno_pkg::DEG_W + 3 * DIST_BITS + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// beam requests
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [IN_TDATA_W-1:0]              s_tdata,   // range_mm
	input  logic                               s_tuser,   // no_return
	input  logic                               s_tlast,   // last_beam
	// scan results
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [OUT_TDATA_W-1:0]             m_tdata,   // closest_angle_deg,
	                                                      // closest_distance_mm,
	                                                      // left_clearance_mm,
	                                                      // right_clearance_mm
	output logic                               m_tuser,   // window_valid
	// configuration
	input  logic                               cfg_we,
	input  logic [lwno_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lwno_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lwno_pkg::*;

	localparam logic signed [20:0] TURN_CFG = 21'(FULL_TURN_MDEG);
	localparam logic signed [20:0] HALF_CFG = 21'(HALF_TURN_MDEG);

	// configuration registers
	logic [DEG_W-1:0]          win_start_q;
	logic [DEG_W-1:0]          win_end_q;
	logic signed [ANGLE_W-1:0] scan_start_q;
	logic [STEP_W-1:0]         scan_step_q;
	logic [RANGE_W-1:0]        floor_q;
	logic [RANGE_W-1:0]        ceiling_q;

	// input stage
	logic                      valid_s1;
	logic [DIST_BITS-1:0]      range_s1;
	logic                      no_ret_s1;
	logic                      last_s1;

	// scan accumulators
	logic signed [ANGLE_W-1:0] angle_q;
	logic                      any_hit_q;
	logic [DIST_BITS-1:0]      near_q;
	logic signed [DEG_W-1:0]   near_deg_q;
	logic [DIST_BITS-1:0]      left_q;
	logic [DIST_BITS-1:0]      right_q;

	// output register
	logic                      out_valid_q;
	logic                      res_hit_q;
	logic signed [DEG_W-1:0]   res_deg_q;
	logic [DIST_BITS-1:0]      res_near_q;
	logic [DIST_BITS-1:0]      res_left_q;
	logic [DIST_BITS-1:0]      res_right_q;

	beam_eval_t                ev;
	logic [DIST_BITS-1:0]      dist_mm;
	logic                      s_accept;
	logic                      advance;
	logic                      hit_new;
	logic [DIST_BITS-1:0]      left_new;
	logic [DIST_BITS-1:0]      right_new;
	logic [DIST_BITS-1:0]      near_new;
	logic signed [DEG_W-1:0]   near_deg_new;
	logic signed [20:0]        start_raw;
	logic signed [20:0]        start_norm;

	// handshake
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	// per-beam evaluation
	lwno_beam_eval #(
		.DIST_BITS(DIST_BITS)
	) u_eval (
		.angle         (angle_q),
		.scan_step     (scan_step_q),
		.win_start     (win_start_q),
		.win_end       (win_end_q),
		.range_floor   (floor_q),
		.range_ceiling (ceiling_q),
		.range_mm      (range_s1),
		.no_return     (no_ret_s1),
		.ev            (ev),
		.dist_mm       (dist_mm)
	);

	// accumulator update for the beam in the input stage
	always_comb begin
		hit_new      = any_hit_q || ev.in_window;
		left_new     = left_q;
		right_new    = right_q;
		near_new     = near_q;
		near_deg_new = near_deg_q;
		if (ev.in_window) begin
			if (ev.left_side && (dist_mm > left_q)) begin
				left_new = dist_mm;
			end
			if (!ev.left_side && (dist_mm > right_q)) begin
				right_new = dist_mm;
			end
			if (dist_mm < near_q) begin
				near_new     = dist_mm;
				near_deg_new = ev.round_deg;
			end
		end
	end

	// scan start wrapped to [-180000,180000)
	always_comb begin
		start_raw = $signed({cfg_data[CFG_DATA_W-1], cfg_data});
		if (start_raw >= HALF_CFG) begin
			start_norm = start_raw - TURN_CFG;
		end else if (start_raw < -HALF_CFG) begin
			start_norm = start_raw + TURN_CFG;
		end else begin
			start_norm = start_raw;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q  <= DEG_W'(WIN_START_RST);
			win_end_q    <= DEG_W'(WIN_END_RST);
			scan_start_q <= '0;
			scan_step_q  <= STEP_W'(SCAN_STEP_RST);
			floor_q      <= RANGE_W'(FLOOR_RST);
			ceiling_q    <= RANGE_W'(CEILING_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIN_START:  win_start_q  <= cfg_data[DEG_W-1:0];
				REG_WIN_END:    win_end_q    <= cfg_data[DEG_W-1:0];
				REG_SCAN_START: scan_start_q <= start_norm[ANGLE_W-1:0];
				REG_SCAN_STEP:  scan_step_q  <= cfg_data[STEP_W-1:0];
				REG_FLOOR:      floor_q      <= cfg_data[RANGE_W-1:0];
				REG_CEILING:    ceiling_q    <= cfg_data[RANGE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (s_accept) begin
			range_s1  <= s_tdata[DIST_BITS-1:0];
			no_ret_s1 <= s_tuser;
			last_s1   <= s_tlast;
		end
	end

	// scan accumulators, cleared after the last beam
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q    <= '0;
			any_hit_q  <= 1'b0;
			near_q     <= '1;
			near_deg_q <= '0;
			left_q     <= '0;
			right_q    <= '0;
		end else if (cfg_we && (cfg_index == REG_SCAN_START)) begin
			angle_q <= start_norm[ANGLE_W-1:0];
		end else if (advance) begin
			if (last_s1) begin
				angle_q    <= scan_start_q;
				any_hit_q  <= 1'b0;
				near_q     <= '1;
				near_deg_q <= '0;
				left_q     <= '0;
				right_q    <= '0;
			end else begin
				angle_q    <= ev.next_angle;
				any_hit_q  <= hit_new;
				near_q     <= near_new;
				near_deg_q <= near_deg_new;
				left_q     <= left_new;
				right_q    <= right_new;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_hit_q   <= hit_new;
			res_deg_q   <= near_deg_new;
			res_near_q  <= near_new;
			res_left_q  <= left_new;
			res_right_q <= right_new;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_hit_q;
	assign m_tdata  = OUT_TDATA_W'({res_right_q, res_left_q, res_near_q, res_deg_q});

endmodule

`default_nettype wire

/* hw/rtl/lwno_beam_eval.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lwno_beam_eval
// Combinational per-beam evaluation: window test, distance sanitizing,
// rounded angle and next beam angle.
// ----------------------------------------------------------------------------
module lwno_beam_eval #(
	parameter int DIST_BITS = 17
) (
	input  logic signed [lwno_pkg::ANGLE_W-1:0] angle,
	input  logic [lwno_pkg::STEP_W-1:0]         scan_step,
	input  logic [lwno_pkg::DEG_W-1:0]          win_start,
	input  logic [lwno_pkg::DEG_W-1:0]          win_end,
	input  logic [lwno_pkg::RANGE_W-1:0]        range_floor,
	input  logic [lwno_pkg::RANGE_W-1:0]        range_ceiling,
	input  logic [DIST_BITS-1:0]                range_mm,
	input  logic                                no_return,
	output lwno_pkg::beam_eval_t                ev,
	output logic [DIST_BITS-1:0]                dist_mm
);
	import lwno_pkg::*;

	localparam int CW = (DIST_BITS > RANGE_W) ? DIST_BITS : RANGE_W;
	localparam logic [DIST_BITS-1:0] BAD_DIST =
		(DIST_BITS >= RANGE_W) ? DIST_BITS'(BAD_READING_MM) : '1;

	localparam logic signed [10:0] TURN_DEG   = 11'(FULL_TURN_DEG);
	localparam logic signed [21:0] TURN_REL   = 22'(FULL_TURN_MDEG);
	localparam logic signed [20:0] TURN_NXT   = 21'(FULL_TURN_MDEG);
	localparam logic signed [20:0] HALF_NXT   = 21'(HALF_TURN_MDEG);

	logic signed [10:0]           diff_deg;
	logic [DEG_W-1:0]             span_deg;
	logic [ANGLE_W-1:0]           span_end;
	logic signed [19:0]           start_mdeg;
	logic signed [21:0]           rel;
	logic signed [21:0]           rel_wrap;
	logic [CW-1:0]                range_w;
	logic                         bad;
	logic [MAG_W-1:0]             mag;
	logic [MAG_W-1:0]             mag_half;
	logic [MAG_W+RECIP_W-1:0]     prod;
	logic [ROUND_W-1:0]           quot;
	logic signed [20:0]           nxt;
	logic signed [20:0]           nxt_wrap;
	logic                         in_window;
	logic                         left_side;
	logic signed [DEG_W-1:0]      round_deg;
	logic signed [ANGLE_W-1:0]    next_angle;

	// window span in degrees, wrapped to [0,360)
	always_comb begin
		diff_deg = $signed({{2{win_end[DEG_W-1]}}, win_end})
			- $signed({{2{win_start[DEG_W-1]}}, win_start});
		if (diff_deg < -TURN_DEG) begin
			diff_deg = diff_deg + TURN_DEG + TURN_DEG;
		end else if (diff_deg < 0) begin
			diff_deg = diff_deg + TURN_DEG;
		end else if (diff_deg >= TURN_DEG) begin
			diff_deg = diff_deg - TURN_DEG;
		end
		span_deg = diff_deg[DEG_W-1:0];
		span_end = ANGLE_W'(span_deg) * ANGLE_W'(MDEG_PER_DEG);
	end

	// beam offset from the window start, wrapped to [0,360000)
	always_comb begin
		start_mdeg = $signed({{11{win_start[DEG_W-1]}}, win_start})
			* $signed(20'(MDEG_PER_DEG));
		rel = $signed({{3{angle[ANGLE_W-1]}}, angle})
			- $signed({{2{start_mdeg[19]}}, start_mdeg});
		if (rel < -TURN_REL) begin
			rel_wrap = rel + TURN_REL + TURN_REL;
		end else if (rel < 0) begin
			rel_wrap = rel + TURN_REL;
		end else if (rel >= TURN_REL) begin
			rel_wrap = rel - TURN_REL;
		end else begin
			rel_wrap = rel;
		end
		in_window = rel_wrap[ANGLE_W-1:0] <= span_end;
		left_side = !angle[ANGLE_W-1];
	end

	// distance sanitizing
	always_comb begin
		range_w = CW'(range_mm);
		bad = no_return || (range_mm == '0) || (range_w < CW'(range_floor))
			|| ((range_ceiling != CEIL_NO_LIMIT) && (range_w > CW'(range_ceiling)));
		dist_mm = bad ? BAD_DIST : range_mm;
	end

	// angle rounded half away from zero
	always_comb begin
		mag      = angle[ANGLE_W-1] ? MAG_W'(-angle) : MAG_W'(angle);
		mag_half = mag + MAG_W'(HALF_DEG_MDEG);
		prod     = (MAG_W+RECIP_W)'(mag_half) * (MAG_W+RECIP_W)'(RECIP_1000);
		quot     = prod[RECIP_SHIFT +: ROUND_W];
		round_deg = angle[ANGLE_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
	end

	// next beam angle, wrapped to [-180000,180000)
	always_comb begin
		nxt = $signed({{2{angle[ANGLE_W-1]}}, angle}) + $signed({2'b00, scan_step});
		if (nxt >= HALF_NXT + TURN_NXT) begin
			nxt_wrap = nxt - TURN_NXT - TURN_NXT;
		end else if (nxt >= HALF_NXT) begin
			nxt_wrap = nxt - TURN_NXT;
		end else begin
			nxt_wrap = nxt;
		end
		next_angle = nxt_wrap[ANGLE_W-1:0];
	end

	// per-beam results
	assign ev = {in_window, left_side, round_deg, next_angle};

endmodule

`default_nettype wire
